// ----- hdl/lucas_lehmer_mersenne_test_core_defines.svh -----
// Assertion macros shared by the Lucas-Lehmer test core modules.
// No dependencies; included by the files that carry assertions.
`ifndef LUCAS_LEHMER_MERSENNE_TEST_CORE_DEFINES_SVH
`define LUCAS_LEHMER_MERSENNE_TEST_CORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define LLMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("llmt assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define LLMT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("llmt assertion failed");

`endif

// ----- hdl/llmt_pkg.sv -----
// Package for the Lucas-Lehmer test core: constants, controller state type,
// and the command and status structs between controller and datapath.
`default_nettype none

package llmt_pkg;

   // Width of the exponent field.
   localparam int LLMT_EXP_W = 6;
   // Default largest exponent that is tested.
   localparam int LLMT_MAX_EXPONENT = 32;
   // Starting residue and the offset subtracted after each squaring.
   localparam int LLMT_SEED = 4;
   localparam int LLMT_OFFSET = 2;

   // Controller states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SQUARE = 4'b0010,
      ST_REDUCE = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic square;
      logic reduce;
      logic publish;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic trivial;
      logic last_iter;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- hdl/llmt_dpath.sv -----
// Datapath of the Lucas-Lehmer test core: residue, squarer, Mersenne
// reduction, iteration counter and result register. Uses llmt_pkg.
`default_nettype none
`include "lucas_lehmer_mersenne_test_core_defines.svh"

module llmt_dpath
   import llmt_pkg::*;
#(
   parameter int MAX_EXPONENT = LLMT_MAX_EXPONENT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [LLMT_EXP_W-1:0] req_exponent,
   input  wire ctrl_cmd_type          cmd,
   output dp_status_type              status,
   output logic                       rsp_prime
);

   localparam int RES_W  = MAX_EXPONENT;
   localparam int SUM_W  = RES_W + 1;
   localparam int PROD_W = 2 * RES_W;

   logic [LLMT_EXP_W-1:0] exp_ff, exp_in;
   logic [LLMT_EXP_W-1:0] iter_ff, iter_in;
   logic [RES_W-1:0]      residue_ff, residue_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  trivial_ff, trivial_in;
   logic                  direct_ff, direct_in;
   logic                  prime_ff, prime_in;

   logic                  req_trivial;
   logic [RES_W-1:0]      mask;
   logic [RES_W-1:0]      prod_lo;
   logic [RES_W-1:0]      prod_hi;
   logic [SUM_W-1:0]      fold_sum;
   logic [SUM_W-1:0]      fold_minus;
   logic [SUM_W-1:0]      mask_ext;
   logic [RES_W-1:0]      reduced;

   // Exponents outside the tested range and exponent two need no loop.
   always_comb begin
      req_trivial = (req_exponent < LLMT_EXP_W'(LLMT_OFFSET))
                 || (req_exponent > LLMT_EXP_W'(MAX_EXPONENT))
                 || (req_exponent == LLMT_EXP_W'(LLMT_OFFSET));
   end

   assign status.trivial   = req_trivial;
   assign status.last_iter = (iter_ff == LLMT_EXP_W'(1));

   // Modulus 2^p - 1 as a mask of p ones.
   assign mask     = ~({RES_W{1'b1}} << exp_ff);
   assign mask_ext = {1'b0, mask};

   // Fold the square at bit p, then subtract two modulo 2^p - 1.
   // The folded sum lies in 0..2m, so one correction in either direction suffices.
   always_comb begin
      prod_lo    = prod_ff[RES_W-1:0] & mask;
      prod_hi    = RES_W'(prod_ff >> exp_ff);
      fold_sum   = {1'b0, prod_lo} + {1'b0, prod_hi};
      fold_minus = fold_sum - SUM_W'(LLMT_OFFSET);
      if (fold_sum < SUM_W'(LLMT_OFFSET)) begin
         reduced = RES_W'(fold_minus + mask_ext);
      end else if (fold_minus >= mask_ext) begin
         reduced = RES_W'(fold_minus - mask_ext);
      end else begin
         reduced = RES_W'(fold_minus);
      end
   end

   // Next values of the datapath registers.
   always_comb begin
      exp_in      = exp_ff;
      iter_in     = iter_ff;
      residue_in  = residue_ff;
      trivial_in  = trivial_ff;
      direct_in   = direct_ff;
      prime_in    = prime_ff;
      prod_in     = PROD_W'(residue_ff) * PROD_W'(residue_ff);
      if (cmd.start) begin
         exp_in     = req_exponent;
         iter_in    = req_exponent - LLMT_EXP_W'(LLMT_OFFSET);
         residue_in = RES_W'(LLMT_SEED);
         trivial_in = req_trivial;
         direct_in  = (req_exponent == LLMT_EXP_W'(LLMT_OFFSET));
      end
      if (cmd.reduce) begin
         residue_in = reduced;
         iter_in    = iter_ff - LLMT_EXP_W'(1);
      end
      if (cmd.publish) begin
         prime_in = trivial_ff ? direct_ff : (residue_ff == '0);
      end
   end

   // Payload registers; no reset needed.
   always_ff @(posedge clock) begin
      exp_ff      <= exp_in;
      iter_ff     <= iter_in;
      residue_ff  <= residue_in;
      trivial_ff  <= trivial_in;
      direct_ff   <= direct_in;
      prime_ff    <= prime_in;
      if (cmd.square) begin
         prod_ff <= prod_in;
      end
   end

   assign rsp_prime = prime_ff;

   // The residue always stays below the modulus after a reduction step.
   `LLMT_ASSERT_NEXT(a_residue_in_range, clock, reset, cmd.reduce, residue_ff < mask)
   // A nontrivial item starts with at least one squaring to do.
   `LLMT_ASSERT_NEXT(a_iter_nonzero, clock, reset, cmd.start && !req_trivial, iter_ff != '0)

endmodule

`default_nettype wire

// ----- hdl/llmt_ctrl.sv -----
// Controller of the Lucas-Lehmer test core: sequences the squaring loop and
// owns the handshakes. Uses llmt_pkg.
`default_nettype none
`include "lucas_lehmer_mersenne_test_core_defines.svh"

module llmt_ctrl
   import llmt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new item when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = status.trivial ? ST_DONE : ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_REDUCE;
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            state_in   = status.last_iter ? ST_DONE : ST_SQUARE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid is set on publish and cleared once the item is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A published item is offered in the following cycle.
   `LLMT_ASSERT_NEXT(a_publish_valid, clock, reset, cmd.publish, rsp_valid_ff)
   // A nontrivial item goes straight to its first squaring.
   `LLMT_ASSERT_NEXT(a_start_square, clock, reset,
      cmd.start && !status.trivial, state_ff == ST_SQUARE)
   // A finished item waits while the result register is still held.
   `LLMT_ASSERT_NEXT(a_done_waits, clock, reset,
      state_ff == ST_DONE && rsp_valid_ff && rsp_stall, state_ff == ST_DONE)
   // Publishing happens only when the result register can take it.
   `LLMT_ASSERT_SAME(a_publish_free, clock, reset, cmd.publish, out_free)

endmodule

`default_nettype wire

// ----- hdl/lucas_lehmer_mersenne_test_core.sv -----
// Lucas-Lehmer test core: an item with 3 <= p <= MAX_EXPONENT runs the squaring loop before
// its result is published; exponents settled without the loop are published directly.
// One item at a time; the next item is accepted once the previous one is published. Each
// loop step is a multiply state followed by a reduce state, and a publish state ends the item.
// A held result delays the next publish but not acceptance.
// Reset (synchronous, active high) clears the controller state and the result valid flag.
`default_nettype none

module lucas_lehmer_mersenne_test_core
   import llmt_pkg::*;
#(
   parameter int MAX_EXPONENT = LLMT_MAX_EXPONENT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [LLMT_EXP_W-1:0] req_exponent,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_prime
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer for the squaring loop and the handshakes.
   llmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Residue arithmetic and result register.
   llmt_dpath #(
      .MAX_EXPONENT (MAX_EXPONENT)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_exponent (req_exponent),
      .cmd          (cmd),
      .status       (status),
      .rsp_prime    (rsp_prime)
   );

endmodule

`default_nettype wire

// ----- sim/lucas_lehmer_mersenne_test_core_tb.sv -----
// Self-checking testbench for the Lucas-Lehmer Mersenne test core.
// Depends on llmt_pkg and lucas_lehmer_mersenne_test_core; predicts every result
// with its own Lucas-Lehmer computation and checks the results in order.
`timescale 1ns / 100ps

module lucas_lehmer_mersenne_test_core_tb;
   import llmt_pkg::*;

   localparam int MAX_EXPONENT = LLMT_MAX_EXPONENT;
   localparam int ITEMS_PER_PHASE = 550;
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_REPORTS = 10;

   // One pending input item; the sender holds it back until nothing is outstanding
   // when wait_for_drain is set.
   typedef struct {
      logic [LLMT_EXP_W-1:0] exponent;
      bit                    wait_for_drain;
   } exponent_item_type;

   // One predicted result, kept with the exponent that caused it.
   typedef struct {
      logic [LLMT_EXP_W-1:0] exponent;
      logic                  prime;
   } primality_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [LLMT_EXP_W-1:0] req_exponent = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_prime;

   exponent_item_type pending_exponents[$];
   primality_type     expected_primality[$];
   int                sender_idle_pct = 7;
   int                receiver_stall_pct = 49;
   int                mismatch_count = 0;
   int                cycle_count = 0;

   lucas_lehmer_mersenne_test_core #(
      .MAX_EXPONENT(MAX_EXPONENT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_exponent(req_exponent),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_prime(rsp_prime)
   );

   // Clock with a 2 ns period.
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Lucas-Lehmer test of 2^p - 1, with the subtraction of two taken modulo 2^p - 1.
   function automatic logic predict_mersenne_prime(logic [LLMT_EXP_W-1:0] p);
      logic [63:0] modulus;
      logic [63:0] residue;
      logic [63:0] square;
      if (p < 2 || p > MAX_EXPONENT) return 1'b0;
      if (p == 2) return 1'b1;
      modulus = (64'd1 << p) - 64'd1;
      residue = 64'(LLMT_SEED);
      for (int i = 0; i < int'(p) - 2; i++) begin
         square = (residue * residue) % modulus;
         if (square >= 64'(LLMT_OFFSET))
            residue = square - 64'(LLMT_OFFSET);
         else
            residue = square + modulus - 64'(LLMT_OFFSET);
      end
      return residue == 64'd0;
   endfunction

   task automatic queue_exponent(logic [LLMT_EXP_W-1:0] exponent, bit wait_for_drain);
      exponent_item_type item;
      item.exponent = exponent;
      item.wait_for_drain = wait_for_drain;
      pending_exponents.push_back(item);
   endtask

   // Mostly exponents that run the loop, with the trivial and out-of-range ones mixed in.
   task automatic queue_random_exponents(int count);
      int pick;
      logic [LLMT_EXP_W-1:0] exponent;
      for (int n = 0; n < count; n++) begin
         pick = int'($urandom_range(99));
         if (pick < 78)
            exponent = LLMT_EXP_W'($urandom_range(MAX_EXPONENT, 3));
         else if (pick < 86)
            exponent = LLMT_EXP_W'($urandom_range(2, 0));
         else
            exponent = LLMT_EXP_W'($urandom_range(63, MAX_EXPONENT + 1));
         queue_exponent(exponent, $urandom_range(149) == 0);
      end
   endtask

   // Driver: records each accepted item's prediction and presents the next item.
   always @(posedge clock) begin
      exponent_item_type next_item;
      primality_type     prediction;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            prediction.exponent = req_exponent;
            prediction.prime = predict_mersenne_prime(req_exponent);
            expected_primality.push_back(prediction);
         end
         // A stalled item stays on the port unchanged.
         if (!(req_valid && req_stall)) begin
            if (pending_exponents.size() != 0
                && !(pending_exponents[0].wait_for_drain && expected_primality.size() != 0)
                && $urandom_range(99) >= sender_idle_pct) begin
               next_item = pending_exponents.pop_front();
               req_valid <= 1'b1;
               req_exponent <= next_item.exponent;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stalls at random and checks each accepted result against the oldest prediction.
   always @(posedge clock) begin
      primality_type prediction;
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_primality.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("ERROR: result prime=%0d arrived with no item outstanding",
                        rsp_prime);
         end else begin
            prediction = expected_primality.pop_front();
            if (rsp_prime !== prediction.prime) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("ERROR: exponent %0d: prime expected %0d, got %0d",
                           prediction.exponent, prediction.prime, rsp_prime);
            end
         end
      end
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: timed out after %0d cycles", cycle_count);
         $display("lucas_lehmer_mersenne_test_core_tb: FAIL");
         $finish;
      end
   end

   // Stimulus in three idling phases, then the final check.
   initial begin
      // Directed items: trivial exponents, known Mersenne primes and composites,
      // the top of the range, just past it, and the all-ones exponent.
      queue_exponent(6'd0, 1'b0);
      queue_exponent(6'd1, 1'b0);
      queue_exponent(6'd2, 1'b0);
      queue_exponent(6'd3, 1'b0);
      queue_exponent(6'd4, 1'b0);
      queue_exponent(6'd5, 1'b0);
      queue_exponent(6'd7, 1'b0);
      queue_exponent(6'd11, 1'b0);
      queue_exponent(6'd13, 1'b0);
      queue_exponent(6'd17, 1'b0);
      queue_exponent(6'd19, 1'b0);
      queue_exponent(6'd23, 1'b0);
      queue_exponent(6'd29, 1'b0);
      queue_exponent(6'd31, 1'b0);
      queue_exponent(6'd32, 1'b0);
      queue_exponent(6'd33, 1'b0);
      queue_exponent(6'd42, 1'b0);
      queue_exponent(6'd63, 1'b0);
      // This item waits until every earlier result has come back.
      queue_exponent(6'd31, 1'b1);
      queue_exponent(6'd2, 1'b0);
      queue_exponent(6'd62, 1'b0);
      queue_random_exponents(ITEMS_PER_PHASE);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_exponents.size() != 0) @(posedge clock);
      sender_idle_pct <= 49;
      receiver_stall_pct <= 7;
      queue_random_exponents(ITEMS_PER_PHASE);

      while (pending_exponents.size() != 0) @(posedge clock);
      sender_idle_pct <= 0;
      receiver_stall_pct <= 0;
      queue_random_exponents(ITEMS_PER_PHASE);

      // Wait for every item to be accepted and answered, then let the block settle.
      while (pending_exponents.size() != 0 || req_valid || expected_primality.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_primality.size() != 0) begin
         mismatch_count++;
         $display("ERROR: %0d results never arrived", expected_primality.size());
      end
      if (mismatch_count == 0) begin
         $display("lucas_lehmer_mersenne_test_core_tb: PASS");
      end else begin
         $display("lucas_lehmer_mersenne_test_core_tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- lucas_lehmer_mersenne_test_core.f -----
+incdir+hdl
hdl/llmt_pkg.sv
hdl/llmt_dpath.sv
hdl/llmt_ctrl.sv
hdl/lucas_lehmer_mersenne_test_core.sv
sim/lucas_lehmer_mersenne_test_core_tb.sv
